// File: hdl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the local binary pattern histogram block.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int DIM_BITS     = 11;
  localparam int BIN_COUNT    = 256;
  localparam int COUNT_BITS   = 20;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCOUNT_BITS  = 3;
  localparam logic [DIM_BITS-1:0] DIM_RESET = 11'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel;
    logic       frame_start;
    logic [7:0] bin_index;
  } lbp_in_t;

  typedef struct packed {
    logic                  result_kind;
    logic [7:0]            lbp_code;
    logic [COUNT_BITS-1:0] bin_count;
    logic                  frame_done;
  } lbp_out_t;

  typedef enum logic [1:0] {
    ENTRY_CODE,
    ENTRY_READ,
    ENTRY_CLEAR
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [7:0]  key;
    logic        frame_done;
  } lbp_entry_t;

endpackage

// File: hdl/lbp_code_histogram.sv
// ----------------------------------------------------------------------------
// lbp_code_histogram
// Streaming 8-neighbour local binary pattern codes with a 256-bin histogram.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  input    | in_valid, in_stall, in_beat           | items in
//  output   | out_valid, out_stall, out_beat        | results out
//  config   | psel, penable, pwrite, paddr, pwdata  | register access
//
// One item per cycle is taken while in_stall is low; a result is registered
// in turn by the line buffer read, the window stage, the queue, the histogram
// read-modify-write and the output register before it is valid. Reset clears
// positions, window, queue and all histogram bins at once. An output stall
// holds the back end while the front keeps filling the four-entry queue.
// ----------------------------------------------------------------------------
module lbp_code_histogram
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  lbp_in_t     in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output lbp_out_t    out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DIM_BITS-1:0]    image_width;
  logic [DIM_BITS-1:0]    image_height;
  logic                   accept;
  logic                   busy;
  logic                   push;
  lbp_entry_t             push_entry;
  logic                   pop;
  lbp_entry_t             head;
  logic                   not_empty;
  logic [QCOUNT_BITS-1:0] count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? 32'(image_height) : 32'(image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        image_width <= pwdata[DIM_BITS-1:0];
      end else begin
        image_height <= pwdata[DIM_BITS-1:0];
      end
    end
  end

  assign in_stall = (QCOUNT_BITS'(count) + QCOUNT_BITS'(busy)) >= QCOUNT_BITS'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  lbp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_beat     (in_beat),
    .image_width (image_width),
    .image_height(image_height),
    .busy        (busy),
    .push        (push),
    .push_entry  (push_entry)
  );

  lbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (count)
  );

  lbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .not_empty(not_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

endmodule

// File: hdl/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lbp_queue.sv
// ----------------------------------------------------------------------------
// lbp_queue
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module lbp_queue
  import lbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lbp_entry_t             push_entry,
  input  logic                   pop,
  output lbp_entry_t             head,
  output logic                   not_empty,
  output logic [QCOUNT_BITS-1:0] count
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  lbp_entry_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic          do_push;
  logic          do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign do_push   = push && (count != QCOUNT_BITS'(QUEUE_DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCOUNT_BITS'(do_push) - QCOUNT_BITS'(do_pop);
    end
  end

endmodule

// File: hdl/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Raster position tracking, line buffers, 3x3 window and pattern forming.
// ----------------------------------------------------------------------------
module lbp_front
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lbp_in_t             in_beat,
  input  logic [DIM_BITS-1:0] image_width,
  input  logic [DIM_BITS-1:0] image_height,
  output logic                busy,
  output logic                push,
  output lbp_entry_t          push_entry
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int DW0 = (AW + 1 > RW) ? AW + 1 : RW;
  localparam int DW  = ((DW0 > DIM_BITS) ? DW0 : DIM_BITS) + 1;

  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic [DW-1:0] w_cl, h_cl, w_in, h_in;
  logic [DW-1:0] col0, row0, col1, row1, cinc;
  logic          wrap, frame_over, end_row, is_pixel, place;

  logic          s1_valid, s1_read, s1_place, s1_emit, s1_clear, s1_done;
  logic [7:0]    s1_pix, s1_bin;
  logic [AW-1:0] s1_addr;
  logic          fwd;
  logic [15:0]   fwd_data;
  logic [15:0]   line_q, line_use, line_wr;
  logic [7:0]    win [9];
  logic [7:0]    nw [9];
  logic [7:0]    code;

  assign w_in = DW'(image_width);
  assign h_in = DW'(image_height);
  assign w_cl = (w_in == '0) ? DW'(1) : ((w_in > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : w_in);
  assign h_cl = (h_in == '0) ? DW'(1) : ((h_in > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : h_in);

  assign is_pixel   = (in_beat.opcode == OP_PIXEL);
  assign col0       = in_beat.frame_start ? '0 : DW'(col);
  assign row0       = in_beat.frame_start ? '0 : DW'(row);
  assign wrap       = (row0 < h_cl) && (col0 >= w_cl);
  assign col1       = wrap ? '0 : col0;
  assign row1       = wrap ? row0 + 1'b1 : row0;
  assign frame_over = (row1 >= h_cl);
  assign place      = accept && is_pixel && !frame_over;
  assign cinc       = col1 + 1'b1;
  assign end_row    = (cinc >= w_cl);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept && is_pixel) begin
      if (frame_over) begin
        col <= col1[AW-1:0];
        row <= h_cl[RW-1:0];
      end else if (end_row) begin
        col <= '0;
        row <= RW'(row1 + 1'b1);
      end else begin
        col <= cinc[AW-1:0];
        row <= row1[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd      <= place && s1_place && (col1[AW-1:0] == s1_addr);
    end
    s1_read  <= !is_pixel;
    s1_place <= place;
    s1_clear <= accept && is_pixel && in_beat.frame_start;
    s1_emit  <= place && (row1 >= DW'(2)) && (col1 >= DW'(2));
    s1_done  <= (row1 == h_cl - 1'b1) && (col1 == w_cl - 1'b1);
    s1_pix   <= in_beat.pixel;
    s1_bin   <= in_beat.bin_index;
    s1_addr  <= col1[AW-1:0];
    fwd_data <= line_wr;
  end

  lbp_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk    (clk),
    .wr_en  (s1_valid && s1_place),
    .wr_addr(s1_addr),
    .wr_data(line_wr),
    .rd_en  (place),
    .rd_addr(col1[AW-1:0]),
    .rd_data(line_q)
  );

  assign line_use = fwd ? fwd_data : line_q;
  assign line_wr  = {line_use[7:0], s1_pix};

  always_comb begin
    nw[0] = win[1]; nw[1] = win[2]; nw[2] = line_use[15:8];
    nw[3] = win[4]; nw[4] = win[5]; nw[5] = line_use[7:0];
    nw[6] = win[7]; nw[7] = win[8]; nw[8] = s1_pix;
    code[7] = nw[0] > nw[4];
    code[6] = nw[1] > nw[4];
    code[5] = nw[2] > nw[4];
    code[4] = nw[5] > nw[4];
    code[3] = nw[8] > nw[4];
    code[2] = nw[7] > nw[4];
    code[1] = nw[6] > nw[4];
    code[0] = nw[3] > nw[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid && s1_place) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= nw[i];
      end
    end
  end

  always_comb begin
    push_entry.frame_done = 1'b0;
    push_entry.key        = code;
    push_entry.kind       = ENTRY_CODE;
    if (s1_read) begin
      push_entry.kind = ENTRY_READ;
      push_entry.key  = s1_bin;
    end else if (s1_clear) begin
      push_entry.kind = ENTRY_CLEAR;
    end else begin
      push_entry.frame_done = s1_done;
    end
  end

  assign push = s1_valid && (s1_read || s1_clear || (s1_place && s1_emit));
  assign busy = s1_valid;

endmodule

// File: hdl/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Histogram read-modify-write, bin reads and the output register.
// ----------------------------------------------------------------------------
module lbp_back
  import lbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lbp_entry_t head,
  input  logic       not_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output lbp_out_t   out_beat
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  adv;
  logic                  b_valid;
  lbp_entry_t            b_entry;
  logic [BIN_COUNT-1:0]  vbits;
  logic                  fwd;
  logic [COUNT_BITS-1:0] fwd_val;
  logic [COUNT_BITS-1:0] ram_q, value, incr;
  logic                  wr_en;

  assign adv   = !out_valid || !out_stall;
  assign pop   = adv && not_empty;
  assign value = fwd ? fwd_val : (vbits[b_entry.key] ? ram_q : '0);
  assign incr  = (value < COUNT_MAX) ? value + 1'b1 : value;
  assign wr_en = adv && b_valid && (b_entry.kind == ENTRY_CODE);

  lbp_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BIN_COUNT)
  ) u_hist (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(b_entry.key),
    .wr_data(incr),
    .rd_en  (pop),
    .rd_addr(head.key),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      vbits     <= '0;
      fwd       <= 1'b0;
    end else if (adv) begin
      b_valid   <= not_empty;
      out_valid <= b_valid && (b_entry.kind != ENTRY_CLEAR);
      if (b_valid && (b_entry.kind == ENTRY_CLEAR)) begin
        vbits <= '0;
      end else if (wr_en) begin
        vbits[b_entry.key] <= 1'b1;
      end
      if (pop) begin
        fwd <= wr_en && (head.key == b_entry.key);
      end
    end
    if (adv) begin
      if (pop) begin
        b_entry <= head;
        fwd_val <= incr;
      end
      if (b_entry.kind == ENTRY_READ) begin
        out_beat.result_kind <= KIND_COUNT;
        out_beat.lbp_code    <= '0;
        out_beat.frame_done  <= 1'b0;
        out_beat.bin_count   <= value;
      end else begin
        out_beat.result_kind <= KIND_CODE;
        out_beat.lbp_code    <= b_entry.key;
        out_beat.frame_done  <= b_entry.frame_done;
        out_beat.bin_count   <= '0;
      end
    end
  end

endmodule

// File: bench/lbp_code_histogram_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbp_code_histogram_tb
// Streams small gray frames, stray pixels and bin reads into the block under
// random source and sink idling, predicts every pattern code and bin count,
// and checks each output beat in order against the prediction.
// ----------------------------------------------------------------------------
module lbp_code_histogram_tb;
  import lbp_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int CBITS = COUNT_BITS;
  localparam logic [CBITS-1:0] COUNT_TOP = '1;

  typedef struct {
    logic             kind;
    logic [7:0]       code;
    logic [CBITS-1:0] count;
    logic             done;
  } lbp_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lbp_in_t          in_beat = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lbp_out_t         out_beat;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  lbp_in_t          pixel_q[$];
  lbp_result_t      result_q[$];
  int               errors = 0;
  int               src_idle = 0;
  int               snk_idle = 0;
  int               hold_req = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               pushed = 0;

  logic [10:0]      reg_w = DIM_RESET;
  logic [10:0]      reg_h = DIM_RESET;
  logic [7:0]       upper_row[MAXW];
  logic [7:0]       middle_row[MAXW];
  logic [7:0]       win[9] = '{default: '0};
  logic [CBITS-1:0] hist[BIN_COUNT] = '{default: '0};
  int               col = 0;
  int               row = 0;

  lbp_code_histogram dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(logic [10:0] v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void predict_beat(lbp_in_t it);
    int ew;
    int eh;
    int c;
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] code;
    lbp_result_t r;
    ew = clamp_dim(reg_w, MAXW);
    eh = clamp_dim(reg_h, MAXH);
    if (it.opcode == OP_READ) begin
      r = '{KIND_COUNT, 8'd0, hist[it.bin_index], 1'b0};
      result_q = {result_q, r};
      return;
    end
    if (it.frame_start) begin
      foreach (hist[i]) hist[i] = '0;
      col = 0;
      row = 0;
    end
    if (row < eh && col >= ew) begin
      col = 0;
      row++;
    end
    if (row >= eh) begin
      row = eh;
      return;
    end
    c = col;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = it.pixel;
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = it.pixel;
    if (row >= 2 && c >= 2) begin
      code = {win[0] > win[4], win[1] > win[4], win[2] > win[4], win[5] > win[4],
              win[8] > win[4], win[7] > win[4], win[6] > win[4], win[3] > win[4]};
      if (hist[code] != COUNT_TOP) hist[code]++;
      r = '{KIND_CODE, code, '0, (row == eh - 1 && c == ew - 1)};
      result_q = {result_q, r};
    end
    col = c + 1;
    if (col >= ew) begin
      col = 0;
      row++;
    end
  endfunction

  // Source side: offers queued items and predicts each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_beat);
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          in_valid <= 1'b1;
          in_beat <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks accepted beats and stalls at random or for long holds.
  always @(posedge clk) begin
    lbp_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind=%0d code=%0d count=%0d done=%0d", $time,
                   out_beat.result_kind, out_beat.lbp_code, out_beat.bin_count,
                   out_beat.frame_done);
        end else begin
          e = result_q.pop_front();
          if (out_beat.result_kind !== e.kind || out_beat.lbp_code !== e.code ||
              out_beat.bin_count !== e.count || out_beat.frame_done !== e.done) begin
            errors++;
            $display("%0t: expected kind=%0d code=%0d count=%0d done=%0d", $time,
                     e.kind, e.code, e.count, e.done);
            $display("%0t: actual   kind=%0d code=%0d count=%0d done=%0d", $time,
                     out_beat.result_kind, out_beat.lbp_code, out_beat.bin_count,
                     out_beat.frame_done);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < snk_idle);
      end
    end
  end

  task automatic reg_write(logic idx, logic [10:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) reg_w = value;
    else reg_h = value;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pixel_q.size() > 0 || in_valid || result_q.size() > 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic push_pixel(logic [7:0] p, logic fs);
    lbp_in_t it;
    it = '{OP_PIXEL, p, fs, 8'($urandom)};
    pixel_q = {pixel_q, it};
    pushed++;
  endtask

  task automatic push_read(logic [7:0] b);
    lbp_in_t it;
    it = '{OP_READ, 8'($urandom), 1'($urandom), b};
    pixel_q = {pixel_q, it};
    pushed++;
  endtask

  task automatic set_dims(logic [10:0] w, logic [10:0] h);
    drain();
    reg_write(REG_IMAGE_WIDTH, w);
    reg_write(REG_IMAGE_HEIGHT, h);
  endtask

  // A frame of n pixels with random content and interleaved bin reads.
  task automatic push_frame(int n, bit narrow);
    logic [7:0] p;
    for (int i = 0; i < n; i++) begin
      p = narrow ? 8'($urandom_range(100, 103)) : 8'($urandom);
      push_pixel(p, i == 0);
      if ($urandom_range(9) == 0) push_read(8'($urandom));
    end
  endtask

  initial begin
    int ew;
    int eh;
    int n;
    logic [10:0] w;
    logic [10:0] h;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_idle = 10;
    snk_idle = 54;

    push_read(8'd0);
    push_read(8'd255);
    push_frame(40, 1'b0);
    push_read(8'd0);

    for (int b = 0; b < 10; b++) begin
      if (b == 0) set_dims(11'd3, 11'd3);
      for (int i = 0; i < 9; i++) begin
        if (b < 8) push_pixel((i == 4) ? 8'd100 : ((i == b) ? 8'd101 : 8'd100), i == 0);
        else if (b == 8) push_pixel((i == 4) ? 8'd0 : 8'd255, i == 0);
        else push_pixel((i == 4) ? 8'd255 : 8'd0, i == 0);
      end
      push_read(8'd255);
    end
    push_pixel(8'd7, 1'b0);
    push_read(8'd0);
    set_dims(11'd2, 11'd5);
    push_frame(12, 1'b0);
    push_read(8'd0);
    set_dims(11'd0, 11'd0);
    push_frame(4, 1'b0);
    set_dims(11'd2047, 11'd3);
    push_frame(40, 1'b1);
    set_dims(11'd3, 11'd2047);
    push_frame(60, 1'b0);

    set_dims(11'd10, 11'd10);
    hold_req++;
    push_frame(100, 1'b0);
    push_frame(40, 1'b1);

    while (pushed < 1900) begin
      if (pushed > 1270) begin
        src_idle = 0;
        snk_idle = 0;
      end else if (pushed > 630) begin
        src_idle = 54;
        snk_idle = 10;
      end
      case ($urandom_range(19))
        0: w = 11'd0;
        1: w = 11'($urandom_range(1025, 2047));
        2: w = 11'd1024;
        default: w = 11'($urandom_range(1, 12));
      endcase
      case ($urandom_range(19))
        0: h = 11'd0;
        1: h = 11'($urandom_range(1025, 2047));
        default: h = 11'($urandom_range(1, 8));
      endcase
      set_dims(w, h);
      ew = clamp_dim(w, MAXW);
      eh = clamp_dim(h, MAXH);
      n = (ew * eh <= 120) ? ew * eh + $urandom_range(0, 3) : $urandom_range(10, 80);
      if ($urandom_range(7) == 0) push_frame($urandom_range(1, n), 1'b0);
      push_frame(n, $urandom_range(3) == 0);
      for (int k = 0; k < 4; k++) push_read(8'($urandom));
    end

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
hdl/lbp_pkg.sv
hdl/lbp_ram.sv
hdl/lbp_queue.sv
hdl/lbp_front.sv
hdl/lbp_back.sv
hdl/lbp_code_histogram.sv
bench/lbp_code_histogram_tb.sv
